FILE: rtl/core/nfba_pkg.sv
// Shared constants and codes of the next-fit identifier allocator.
`default_nettype none
package nfba_pkg;

  // Payload widths
  localparam int IDX_W    = 11;
  localparam int STATUS_W = 2;

  // Used-map word geometry
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  localparam int INDEX_COUNT_DEFAULT = 2048;

  // Command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/core/nfba_if.sv
// Request and response channel interfaces of the next-fit identifier allocator.
`default_nettype none
interface nfba_req_if;
  import nfba_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] release_index;

  modport source (output valid, output cmd, output release_index, input ready);
  modport sink   (input valid, input cmd, input release_index, output ready);
endinterface

interface nfba_rsp_if;
  import nfba_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    given_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output given_index, output status, input ready);
  modport sink   (input valid, input given_index, input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/next_fit_bitmap_index_allocator_unit.sv
// Next-fit bitmap identifier allocator: used-map in a word memory, scanned one word a cycle.
// Allocate: one memory read per cycle over the NW used-map words (32 at default),
//   with the start word visited twice.
// Release: read at accept, write-back of the cleared bit, output load; a refused one skips to the load.
// A finished result waits in the output register while the next item is accepted.
// After rst the used-map is cleared one word a cycle; no item is accepted then.
`default_nettype none
module next_fit_bitmap_index_allocator_unit #(
  parameter int INDEX_COUNT = nfba_pkg::INDEX_COUNT_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  nfba_req_if.sink  req,
  nfba_rsp_if.source rsp
);
  import nfba_pkg::*;

  localparam int NW   = (INDEX_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int FW   = AW + BIT_W;
  localparam int CW   = $clog2(NW + 2);
  localparam int TAIL = INDEX_COUNT - WORD_W * (NW - 1);
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL == WORD_W) ? '1 : ((WORD_W'(1) << TAIL) - WORD_W'(1));

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_REL, S_PUSH} state_t;

  state_t              state;
  logic [AW-1:0]       ptr;
  logic [CW-1:0]       cnt;
  logic [IDX_W-1:0]    last_given;
  logic [BIT_W-1:0]    start_bit;
  logic                ev_valid;
  logic                ev_first;
  logic                ev_last;
  logic [AW-1:0]       ev_word;
  logic [BIT_W-1:0]    rel_bit;
  logic [IDX_W-1:0]    res_index;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [IDX_W-1:0]    out_index;
  logic [STATUS_W-1:0] out_status;

  // Used-map memory
  logic [WORD_W-1:0] mem [NW];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  logic              accept;
  logic              is_rel;
  logic              rel_ok;
  logic [FW-1:0]     start;
  logic              issue;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] free;
  logic [BIT_W-1:0]  pos;
  logic              hit;
  logic [FW-1:0]     found;
  logic              push;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_rel    = (req.cmd == CMD_RELEASE);
  assign rel_ok    = (req.release_index != '0) && (32'(req.release_index) < INDEX_COUNT);
  assign start     = (32'(last_given) >= INDEX_COUNT) ? '0 : FW'(last_given);
  assign issue     = (state == S_SCAN) && (cnt <= CW'(NW));
  assign push      = (state == S_PUSH) && (!out_valid || rsp.ready);

  // Mask the word under test: start bit split, bits past the last identifier
  always_comb begin
    lo_mask    = (WORD_W'(1) << start_bit) - WORD_W'(1);
    range_mask = (ev_word == AW'(NW - 1)) ? TAIL_MASK : '1;
    free       = ~rd_data & range_mask & (ev_first ? ~lo_mask : '1) & (ev_last ? lo_mask : '1);
    pos        = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free[b]) begin
        pos = BIT_W'(b);
      end
    end
    hit   = ev_valid && (free != '0);
    found = {ev_word, pos};
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (ptr == '0) ? WORD_W'(1) : '0;
      end
      S_IDLE: begin
        rd_en   = accept && is_rel && rel_ok;
        rd_addr = AW'(req.release_index >> BIT_W);
      end
      S_SCAN: begin
        rd_en   = issue;
        wr_en   = hit;
        wr_addr = ev_word;
        wr_data = rd_data | (WORD_W'(1) << pos);
      end
      S_REL: begin
        wr_en   = rd_data[rel_bit];
        wr_addr = ev_word;
        wr_data = rd_data & ~(WORD_W'(1) << rel_bit);
      end
      default: begin
      end
    endcase
  end

  // Control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      ptr        <= '0;
      cnt        <= '0;
      last_given <= IDX_W'(1);
      ev_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // drop the delivered item unless a new one loads this cycle
      if (out_valid && rsp.ready && !push) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (ptr == AW'(NW - 1)) begin
            ptr   <= '0;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_IDLE: begin
          ev_valid <= 1'b0;
          if (accept) begin
            if (is_rel) begin
              ev_word <= AW'(req.release_index >> BIT_W);
              rel_bit <= req.release_index[BIT_W-1:0];
              if (rel_ok) begin
                state <= S_REL;
              end else begin
                res_index  <= '0;
                res_status <= ST_BAD_RELEASE;
                state      <= S_PUSH;
              end
            end else begin
              ptr       <= start[FW-1:BIT_W];
              start_bit <= start[BIT_W-1:0];
              cnt       <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // advance the read pointer, wrapping at the top word
          ev_valid <= issue;
          ev_word  <= ptr;
          ev_first <= (cnt == '0);
          ev_last  <= (cnt == CW'(NW));
          if (issue) begin
            cnt <= cnt + CW'(1);
            ptr <= (ptr == AW'(NW - 1)) ? '0 : ptr + AW'(1);
          end
          if (hit) begin
            last_given <= IDX_W'(found);
            res_index  <= IDX_W'(found);
            res_status <= ST_OK;
            state      <= S_PUSH;
          end else if (ev_valid && ev_last) begin
            res_index  <= '0;
            res_status <= ST_FULL;
            state      <= S_PUSH;
          end
        end
        S_REL: begin
          res_index  <= '0;
          res_status <= rd_data[rel_bit] ? ST_OK : ST_BAD_RELEASE;
          state      <= S_PUSH;
        end
        S_PUSH: begin
          // hold the result until the output register is free
          if (push) begin
            out_valid  <= 1'b1;
            out_index  <= res_index;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.given_index = out_index;
  assign rsp.status      = out_status;

  // Reserved identifier 0 stays marked used on every write of word 0
  a_zero_kept: assert property (@(posedge clk) disable iff (rst)
    (wr_en && wr_addr == '0) |-> wr_data[0])
    else $error("identifier 0 cleared in used-map");

  // No used-map write while waiting for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("used-map written while idle");

  // The search point moves only during a scan
  a_last_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN) |=> $stable(last_given))
    else $error("last given identifier moved outside a scan");

  // A full map or a failed release hands out no identifier
  a_no_index_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_index == '0))
    else $error("identifier returned with error status");

endmodule
`default_nettype wire

FILE: tb/nfba_alloc_monitor.sv
// Watches both channels of the identifier allocator, predicts each result and compares.
`default_nettype none
module nfba_alloc_monitor #(
  parameter int INDEX_COUNT = nfba_pkg::INDEX_COUNT_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  nfba_req_if       req,
  nfba_rsp_if       rsp,
  output int        errors,
  output int        pending
);
  import nfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]    given_index;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  // Own copy of the used-map and the next-fit search point
  bit               id_taken [INDEX_COUNT];
  logic [IDX_W-1:0] search_from;
  alloc_result_t    results_due [$];

  // Apply one item to the used-map and return the result it causes
  function automatic alloc_result_t serve_request(input logic op, input logic [IDX_W-1:0] rel);
    alloc_result_t r;
    int start;
    int hit;
    int i;
    r.given_index = '0;
    r.status      = ST_OK;
    if (op == CMD_ALLOC) begin
      start = int'(search_from);
      if (start >= INDEX_COUNT) start = 0;
      hit = -1;
      // Search at or above the last identifier handed out, then wrap to the bottom
      for (i = start; i < INDEX_COUNT && hit < 0; i++)
        if (!id_taken[i]) hit = i;
      for (i = 0; i < start && hit < 0; i++)
        if (!id_taken[i]) hit = i;
      if (hit < 0) begin
        r.status = ST_FULL;
      end else begin
        id_taken[hit] = 1'b1;
        search_from   = IDX_W'(hit);
        r.given_index = IDX_W'(hit);
      end
    end else if (rel == '0 || int'(rel) >= INDEX_COUNT || !id_taken[rel]) begin
      r.status = ST_BAD_RELEASE;
    end else begin
      id_taken[rel] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      // Identifier 0 stays used forever; the search starts at 1
      foreach (id_taken[k]) id_taken[k] = 1'b0;
      id_taken[0] = 1'b1;
      search_from = IDX_W'(1);
      results_due.delete();
      errors = 0;
    end else begin
      // Compare a delivered item with the oldest expectation
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $error("unexpected result: given_index %0d status %0d", rsp.given_index, rsp.status);
        end else begin
          want = results_due.pop_front();
          if (rsp.given_index !== want.given_index) begin
            errors++;
            $error("given_index mismatch: expected %0d, actual %0d",
                   want.given_index, rsp.given_index);
          end
          if (rsp.status !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
          end
        end
      end
      // Predict the result of an accepted item
      if (req.valid && req.ready)
        results_due.push_back(serve_request(req.cmd, req.release_index));
    end
    pending <= results_due.size();
  end

endmodule
`default_nettype wire

FILE: tb/next_fit_bitmap_index_allocator_unit_tb.sv
// Stimulus and verdict for the next-fit bitmap identifier allocator.
`default_nettype none
module next_fit_bitmap_index_allocator_unit_tb;
  import nfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 500;
  localparam int CHURN_ITEMS = 60;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic map_full_seen;
  logic [IDX_W-1:0] held_ids [$];

  nfba_req_if req_ch ();
  nfba_rsp_if rsp_ch ();

  next_fit_bitmap_index_allocator_unit #(
    .INDEX_COUNT(INDEX_COUNT_DEFAULT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  nfba_alloc_monitor #(
    .INDEX_COUNT(INDEX_COUNT_DEFAULT)
  ) alloc_monitor (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .errors(errors),
    .pending(pending)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Track identifiers handed out so releases can target live ones
  always @(posedge clk) begin
    if (rst) begin
      map_full_seen <= 1'b0;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_ch.status == ST_FULL)
        map_full_seen <= 1'b1;
      else if (rsp_ch.status == ST_OK && rsp_ch.given_index != '0)
        held_ids.push_back(rsp_ch.given_index);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= op;
    req_ch.release_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Hold off the sender until every expected item has come back
  task automatic wait_results_home();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Allocate, release a live identifier, or send a release of 0, the top or a random identifier
  task automatic random_request(input int alloc_pct, input int rel_pct);
    int roll;
    int pick;
    logic [IDX_W-1:0] target;
    roll = $urandom_range(99);
    if (roll < alloc_pct) begin
      send_request(CMD_ALLOC, IDX_W'($urandom_range(2047)));
    end else if (roll < alloc_pct + rel_pct && held_ids.size() != 0) begin
      pick   = $urandom_range(held_ids.size() - 1);
      target = held_ids[pick];
      held_ids.delete(pick);
      send_request(CMD_RELEASE, target);
    end else begin
      case ($urandom_range(3))
        0:       target = '0;
        1:       target = '1;
        default: target = IDX_W'($urandom_range(2047));
      endcase
      send_request(CMD_RELEASE, target);
    end
  endtask

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= CMD_ALLOC;
    req_ch.release_index <= '0;
    tx_idle_pct          <= 18;
    rx_idle_pct          <= 62;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: first grants, bad releases, next-fit reuse of the last grant
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '1);
    send_request(CMD_RELEASE, IDX_W'(1));
    send_request(CMD_RELEASE, IDX_W'(1));
    send_request(CMD_RELEASE, '0);
    send_request(CMD_RELEASE, '1);
    send_request(CMD_RELEASE, IDX_W'('h555));
    send_request(CMD_RELEASE, IDX_W'('h2AA));
    send_request(CMD_ALLOC, IDX_W'('h555));
    send_request(CMD_RELEASE, IDX_W'(2));
    send_request(CMD_RELEASE, IDX_W'(3));
    send_request(CMD_ALLOC, IDX_W'('h2AA));
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_RELEASE, IDX_W'(4));
    send_request(CMD_ALLOC, '0);
    send_request(CMD_RELEASE, IDX_W'(1024));
    send_request(CMD_RELEASE, '0);
    wait_results_home();

    // Allocation-heavy mix, receiver stalling most
    repeat (PHASE_ITEMS) random_request(95, 4);
    wait_results_home();

    // Same mix with the sender idling most
    tx_idle_pct <= 62;
    rx_idle_pct <= 18;
    repeat (PHASE_ITEMS) random_request(95, 4);
    wait_results_home();

    // Fill the map until an allocate is refused, then churn near full
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    while (!map_full_seen) send_request(CMD_ALLOC, IDX_W'($urandom_range(2047)));
    repeat (CHURN_ITEMS) random_request(45, 45);

    wait_results_home();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("next_fit_bitmap_index_allocator_unit test passed");
    end else begin
      $display("next_fit_bitmap_index_allocator_unit test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("next_fit_bitmap_index_allocator_unit test failed");
    $finish;
  end

endmodule
`default_nettype wire
